// ===== rtl/cpt_pkg.sv =====
`timescale 1ns / 1ps
// cpt_pkg: shared widths, report codes, datapath commands and status for the
// child/parent table. No dependencies.
package cpt_pkg;

  localparam int TableDepthDefault = 16;
  localparam int AddrW             = 64;
  localparam int KindW             = 3;
  localparam int SlotW             = 4;
  localparam int TickW             = 4;
  localparam logic [TickW-1:0] LimitReset = 4'd3;
  localparam logic [TickW-1:0] TickMax    = 4'd15;

  typedef enum logic [KindW-1:0] {
    KIND_UPDATED   = 3'd0,
    KIND_ADDED     = 3'd1,
    KIND_DROPPED   = 3'd2,
    KIND_CONNECTED = 3'd3,
    KIND_REMOVED   = 3'd4
  } kind_e;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_READ_IDX,
    DP_READ_LAST,
    DP_NEXT,
    DP_HIT,
    DP_APPEND,
    DP_DROP,
    DP_CONNECT,
    DP_REMOVE,
    DP_MOVE
  } dp_op_e;

  typedef struct packed {
    logic item_tick;  // latched beat is a tick
    logic empty;      // no entries
    logic full;       // no room to append
    logic hit;        // read entry matches the sender
    logic at_end;     // walk index is the last entry
    logic expired;    // read entry reached the miss limit
    logic out_free;   // output register can take a beat
  } dp_status_t;

endpackage

// ===== rtl/cpt_ifs.sv =====
`timescale 1ns / 1ps
// cpt_in_if / cpt_out_if: valid/ready channels for input and report beats.
// Depends on cpt_pkg.
interface cpt_in_if import cpt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [AddrW-1:0] sender_high;
  logic [AddrW-1:0] sender_low;
  logic [AddrW-1:0] parent_high;
  logic [AddrW-1:0] parent_low;

  modport source (output valid, opcode, sender_high, sender_low, parent_high, parent_low,
                  input ready);
  modport sink   (input valid, opcode, sender_high, sender_low, parent_high, parent_low,
                  output ready);
endinterface

interface cpt_out_if import cpt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] report_kind;
  logic [SlotW-1:0] slot;
  logic [AddrW-1:0] child_out_high;
  logic [AddrW-1:0] child_out_low;
  logic [AddrW-1:0] parent_out_high;
  logic [AddrW-1:0] parent_out_low;
  logic             last;

  modport source (output valid, report_kind, slot, child_out_high, child_out_low,
                  parent_out_high, parent_out_low, last, input ready);
  modport sink   (input valid, report_kind, slot, child_out_high, child_out_low,
                  parent_out_high, parent_out_low, last, output ready);
endinterface

// ===== rtl/cpt_ctrl.sv =====
`timescale 1ns / 1ps
// cpt_ctrl: sequencer for search, append or drop, and aging walk.
// Depends on cpt_pkg; drives the datapath through dp_op_e.
module cpt_ctrl import cpt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_op_e     op_o
);

  typedef enum logic [8:0] {
    ST_IDLE      = 9'b0_0000_0001,
    ST_DISPATCH  = 9'b0_0000_0010,
    ST_SRCH_RD   = 9'b0_0000_0100,
    ST_SRCH_CMP  = 9'b0_0000_1000,
    ST_MISS      = 9'b0_0001_0000,
    ST_WALK_RD   = 9'b0_0010_0000,
    ST_WALK_EVAL = 9'b0_0100_0000,
    ST_MOVE_RD   = 9'b0_1000_0000,
    ST_MOVE_WR   = 9'b1_0000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    op_o    = DP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_o    = DP_LOAD;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (status_i.item_tick) begin
          state_d = status_i.empty ? ST_IDLE : ST_WALK_RD;
        end else begin
          state_d = status_i.empty ? ST_MISS : ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: begin
        op_o    = DP_READ_IDX;
        state_d = ST_SRCH_CMP;
      end
      ST_SRCH_CMP: begin
        if (status_i.hit) begin
          if (status_i.out_free) begin
            op_o    = DP_HIT;
            state_d = ST_IDLE;
          end
        end else if (status_i.at_end) begin
          state_d = ST_MISS;
        end else begin
          op_o    = DP_NEXT;
          state_d = ST_SRCH_RD;
        end
      end
      ST_MISS: begin
        if (status_i.out_free) begin
          op_o    = status_i.full ? DP_DROP : DP_APPEND;
          state_d = ST_IDLE;
        end
      end
      ST_WALK_RD: begin
        op_o    = DP_READ_IDX;
        state_d = ST_WALK_EVAL;
      end
      ST_WALK_EVAL: begin
        if (status_i.out_free) begin
          if (status_i.expired) begin
            op_o    = DP_REMOVE;
            state_d = ST_MOVE_RD;
          end else begin
            op_o    = DP_CONNECT;
            state_d = status_i.at_end ? ST_IDLE : ST_WALK_RD;
          end
        end
      end
      ST_MOVE_RD: begin
        op_o    = DP_READ_LAST;
        state_d = ST_MOVE_WR;
      end
      ST_MOVE_WR: begin
        // last entry lands in the freed slot; the slot is walked again
        op_o    = DP_MOVE;
        state_d = status_i.at_end ? ST_IDLE : ST_WALK_RD;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/cpt_dp.sv =====
`timescale 1ns / 1ps
// cpt_dp: entry table memory, walk index, entry count, item latch, limit
// register and report output register. Depends on cpt_pkg.
module cpt_dp import cpt_pkg::*; #(
  parameter int TableDepth = TableDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_op_e           op_i,
  output dp_status_t       status_o,
  input  logic             cfg_we_i,
  input  logic [TickW-1:0] cfg_wdata_i,
  input  logic             in_opcode_i,
  input  logic [AddrW-1:0] in_sender_high_i,
  input  logic [AddrW-1:0] in_sender_low_i,
  input  logic [AddrW-1:0] in_parent_high_i,
  input  logic [AddrW-1:0] in_parent_low_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output kind_e            out_kind_o,
  output logic [SlotW-1:0] out_slot_o,
  output logic [AddrW-1:0] out_child_high_o,
  output logic [AddrW-1:0] out_child_low_o,
  output logic [AddrW-1:0] out_parent_high_o,
  output logic [AddrW-1:0] out_parent_low_o,
  output logic             out_last_o
);

  localparam int IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntW = $clog2(TableDepth + 1);

  typedef struct packed {
    logic [AddrW-1:0] ch;
    logic [AddrW-1:0] cl;
    logic [AddrW-1:0] ph;
    logic [AddrW-1:0] pl;
    logic [TickW-1:0] miss;
  } entry_t;

  entry_t           mem_q [TableDepth];
  entry_t           rd_q;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [TickW-1:0] limit_q;
  logic             tick_q;
  logic [AddrW-1:0] sh_q, sl_q, ph_q, pl_q;

  logic [IdxW-1:0]  last_idx, rd_addr, wr_addr;
  logic             rd_en, wr_en;
  entry_t           wr_data;
  logic             at_end;

  logic             emit;
  kind_e            e_kind;
  logic [IdxW-1:0]  e_idx;
  logic [AddrW-1:0] e_ch, e_cl, e_ph, e_pl;
  logic             e_last;
  logic [TickW-1:0] miss_inc;

  logic             out_valid_q;
  kind_e            kind_q;
  logic [SlotW-1:0] slot_q;
  logic [AddrW-1:0] och_q, ocl_q, oph_q, opl_q;
  logic             last_q;

  assign last_idx = IdxW'(cnt_q - CntW'(1));
  assign at_end   = (CntW'(idx_q) == (cnt_q - CntW'(1)));
  assign miss_inc = (rd_q.miss == TickMax) ? rd_q.miss : rd_q.miss + TickW'(1);

  assign status_o.item_tick = tick_q;
  assign status_o.empty     = (cnt_q == '0);
  assign status_o.full      = (cnt_q == CntW'(TableDepth));
  assign status_o.hit       = (rd_q.ch == sh_q) && (rd_q.cl == sl_q);
  assign status_o.at_end    = at_end;
  assign status_o.expired   = (rd_q.miss >= limit_q);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    rd_en   = 1'b0;
    rd_addr = idx_q;
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = rd_q;
    emit    = 1'b0;
    e_kind  = KIND_CONNECTED;
    e_idx   = idx_q;
    e_ch    = rd_q.ch;
    e_cl    = rd_q.cl;
    e_ph    = rd_q.ph;
    e_pl    = rd_q.pl;
    e_last  = 1'b1;
    case (op_i)
      DP_LOAD: begin
        idx_d = '0;
      end
      DP_READ_IDX: begin
        rd_en = 1'b1;
      end
      DP_READ_LAST: begin
        rd_en   = 1'b1;
        rd_addr = last_idx;
      end
      DP_NEXT: begin
        idx_d = idx_q + IdxW'(1);
      end
      DP_HIT: begin
        wr_en   = 1'b1;
        wr_data = '{ch: rd_q.ch, cl: rd_q.cl, ph: ph_q, pl: pl_q, miss: '0};
        emit    = 1'b1;
        e_kind  = KIND_UPDATED;
        e_ph    = ph_q;
        e_pl    = pl_q;
      end
      DP_APPEND: begin
        wr_en   = 1'b1;
        wr_addr = IdxW'(cnt_q);
        wr_data = '{ch: sh_q, cl: sl_q, ph: ph_q, pl: pl_q, miss: '0};
        cnt_d   = cnt_q + CntW'(1);
        emit    = 1'b1;
        e_kind  = KIND_ADDED;
        e_idx   = IdxW'(cnt_q);
        e_ch    = sh_q;
        e_cl    = sl_q;
        e_ph    = ph_q;
        e_pl    = pl_q;
      end
      DP_DROP: begin
        emit   = 1'b1;
        e_kind = KIND_DROPPED;
        e_idx  = '0;
        e_ch   = sh_q;
        e_cl   = sl_q;
        e_ph   = ph_q;
        e_pl   = pl_q;
      end
      DP_CONNECT: begin
        wr_en        = 1'b1;
        wr_data.miss = miss_inc;
        idx_d        = idx_q + IdxW'(1);
        emit         = 1'b1;
        e_kind       = KIND_CONNECTED;
        e_last       = at_end;
      end
      DP_REMOVE: begin
        emit   = 1'b1;
        e_kind = KIND_REMOVED;
        e_last = at_end;
      end
      DP_MOVE: begin
        wr_en = 1'b1;
        cnt_d = cnt_q - CntW'(1);
      end
      default: begin
      end
    endcase
  end

  // table memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == DP_LOAD) begin
      tick_q <= in_opcode_i;
      sh_q   <= in_sender_high_i;
      sl_q   <= in_sender_low_i;
      ph_q   <= in_parent_high_i;
      pl_q   <= in_parent_low_i;
    end
    if (emit) begin
      kind_q <= e_kind;
      slot_q <= SlotW'(e_idx);
      och_q  <= e_ch;
      ocl_q  <= e_cl;
      oph_q  <= e_ph;
      opl_q  <= e_pl;
      last_q <= e_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      cnt_q       <= '0;
      limit_q     <= LimitReset;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_kind_o        = kind_q;
  assign out_slot_o        = slot_q;
  assign out_child_high_o  = och_q;
  assign out_child_low_o   = ocl_q;
  assign out_parent_high_o = oph_q;
  assign out_parent_low_o  = opl_q;
  assign out_last_o        = last_q;

endmodule

// ===== rtl/child_parent_table_with_aging.sv =====
`timescale 1ns / 1ps
// child_parent_table_with_aging: top level of the child/parent learning table.
// Depends on cpt_pkg, cpt_ifs (cpt_in_if, cpt_out_if), cpt_ctrl, cpt_dp.
//
//   channel  dir  handshake     beat contents
//   in_i     in   valid/ready   opcode, sender_high/low, parent_high/low
//   out_o    out  valid/ready   report_kind, slot, child/parent_out_high/low, last
//   cfg      in   cfg_we_i      cfg_wdata_i -> miss_limit
//
// Steps: a message is latched, then dispatched; each entry searched is read, then
// compared, a hit reporting from its compare state; a miss then appends or drops.
// A tick reads and connects each entry, or removes it and moves the last entry in.
// The pace is set by the single table port: one read with registered data,
// one write per cycle. in_i is ready only between items.
// Reset clears the entry count and output valid and loads the limit with 3; the
// table itself needs no clearing pass. A full output register stalls the sequencer.
module child_parent_table_with_aging import cpt_pkg::*; #(
  parameter int TableDepth = TableDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  cpt_in_if.sink           in_i,
  cpt_out_if.source        out_o,
  input  logic             cfg_we_i,
  input  logic [TickW-1:0] cfg_wdata_i
);

  dp_status_t status;
  dp_op_e     op;
  kind_e      out_kind;

  // sequencer: owns input ready and the order of table operations
  cpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .op_o       (op)
  );

  // table, counters and the report register
  cpt_dp #(
    .TableDepth (TableDepth)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .op_i              (op),
    .status_o          (status),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_opcode_i       (in_i.opcode),
    .in_sender_high_i  (in_i.sender_high),
    .in_sender_low_i   (in_i.sender_low),
    .in_parent_high_i  (in_i.parent_high),
    .in_parent_low_i   (in_i.parent_low),
    .out_valid_o       (out_o.valid),
    .out_ready_i       (out_o.ready),
    .out_kind_o        (out_kind),
    .out_slot_o        (out_o.slot),
    .out_child_high_o  (out_o.child_out_high),
    .out_child_low_o   (out_o.child_out_low),
    .out_parent_high_o (out_o.parent_out_high),
    .out_parent_low_o  (out_o.parent_out_low),
    .out_last_o        (out_o.last)
  );

  assign out_o.report_kind = out_kind;

endmodule
